// ===== rtl/sbus_pkg.sv =====
// Package for the SBUS frame decoder: frame layout constants, register
// indexes, reset values and the sequencer state type.
// No dependencies.
package sbus_pkg;

    localparam int unsigned DataLen  = 22;             // data bytes per frame
    localparam int unsigned DataBits = DataLen * 8;    // 176 packed bits
    localparam int unsigned NumCh    = 16;
    localparam int unsigned ChBits   = 11;
    localparam int unsigned ProdBits = ChBits + 16;    // raw * factor
    localparam int unsigned FracBits = 12;             // Q4.12 factor

    localparam logic [7:0] HdrByte = 8'h0F;
    localparam logic [4:0] PosHunt = 5'd0;
    localparam logic [4:0] PosFlag = 5'd23;

    localparam logic [3:0] LastCh  = 4'(NumCh - 1);
    localparam logic [ProdBits:0] RoundBias = (ProdBits + 1)'(1 << (FracBits - 1));

    localparam int unsigned CfgIdxW = 8;
    localparam logic [CfgIdxW-1:0] CfgScaleFactor = 8'd0;
    localparam logic [CfgIdxW-1:0] CfgScaleOffset = 8'd1;

    localparam logic [15:0] FactorReset = 16'd2560;
    localparam logic [15:0] OffsetReset = 16'd880;

    typedef enum logic [3:0] {
        ST_RECV = 4'b0001,   // taking bytes
        ST_MUL  = 4'b0010,   // multiply current channel
        ST_SUM  = 4'b0100,   // round, add offset, load output
        ST_OUT  = 4'b1000    // result waiting on the master side
    } state_t;

endpackage

// ===== rtl/sbus_scale.sv =====
// Shared scaling unit of the SBUS frame decoder: registered multiply of a
// raw channel by the Q4.12 factor, then round, shift and offset add.
// Depends on sbus_pkg.
module sbus_scale (
    input  logic                              aclk,
    input  logic                              mul_en,
    input  logic [sbus_pkg::ChBits-1:0]       raw,
    input  logic [15:0]                       factor,
    input  logic [15:0]                       offset,
    output logic [15:0]                       value
);

    logic [sbus_pkg::ProdBits-1:0] prod_reg;
    logic [sbus_pkg::ProdBits:0]   biased;

    always_ff @(posedge aclk) begin
        if (mul_en) begin
            prod_reg <= {16'b0, raw} * {{sbus_pkg::ChBits{1'b0}}, factor};
        end
    end

    assign biased = {1'b0, prod_reg} + sbus_pkg::RoundBias;
    // floor((p + 2048) / 4096) plus offset, wrapping at 16 bits
    assign value  = biased[sbus_pkg::ProdBits -: 16] + offset;

endmodule

// ===== rtl/sbus_frame_decoder.sv =====
// SBUS frame decoder, top level: byte hunt and capture, channel sequencer,
// output register and configuration registers.
// Depends on sbus_pkg and sbus_scale.
//
// Bytes enter one per cycle on s_ while the block hunts or collects the 22
// data bytes. The flag byte starts the channel pass: s_tready stays low while
// sixteen channels go one after another through the single multiplier of
// sbus_scale, each through the states multiply, round and offset, and output,
// plus any wait on m_tready. Channel 15 is marked with m_tlast. Config writes
// (index 0 scale_factor, 1 scale_offset, other indexes ignored) are always
// accepted and must only come while idle.
module sbus_frame_decoder (
    input  logic                             aclk,
    input  logic                             aresetn,
    // config write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sbus_pkg::CfgIdxW-1:0]     cfg_index,
    input  logic [15:0]                      cfg_data,
    // byte input
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // [7:0] rx_byte
    // channel results
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [31:0]                      m_tdata,   // [3:0] channel_index,
                                                        // [19:4] channel_value,
                                                        // [27:20] frame_flags
    output logic                             m_tlast
);

    sbus_pkg::state_t state_reg, state_next;

    logic [4:0]                    pos_reg, pos_next;
    logic [3:0]                    ch_reg, ch_next;
    logic [sbus_pkg::DataBits-1:0] data_reg;
    logic [7:0]                    flags_reg;
    logic [15:0]                   value_reg;
    logic [15:0]                   factor_reg;
    logic [15:0]                   offset_reg;
    logic [15:0]                   scaled;
    logic                          s_acc;
    logic                          m_acc;
    logic                          hunting;

    assign s_tready  = (state_reg == sbus_pkg::ST_RECV);
    assign m_tvalid  = (state_reg == sbus_pkg::ST_OUT);
    assign cfg_ready = 1'b1;
    assign s_acc     = s_tvalid && s_tready;
    assign m_acc     = m_tvalid && m_tready;
    assign hunting   = (pos_reg == sbus_pkg::PosHunt) || (pos_reg > sbus_pkg::PosFlag);

    assign m_tdata = {4'b0, flags_reg, value_reg, ch_reg};
    assign m_tlast = (ch_reg == sbus_pkg::LastCh);

    sbus_scale u_scale (
        .aclk   (aclk),
        .mul_en (state_reg == sbus_pkg::ST_MUL),
        .raw    (data_reg[sbus_pkg::ChBits-1:0]),
        .factor (factor_reg),
        .offset (offset_reg),
        .value  (scaled)
    );

    always_comb begin
        state_next = state_reg;
        pos_next   = pos_reg;
        ch_next    = ch_reg;
        unique case (state_reg)
            sbus_pkg::ST_RECV: begin
                if (s_acc) begin
                    if (hunting) begin
                        pos_next = (s_tdata == sbus_pkg::HdrByte) ? 5'd1 : sbus_pkg::PosHunt;
                    end else if (pos_reg < sbus_pkg::PosFlag) begin
                        pos_next = pos_reg + 5'd1;
                    end else begin
                        pos_next   = sbus_pkg::PosHunt;
                        ch_next    = 4'd0;
                        state_next = sbus_pkg::ST_MUL;
                    end
                end
            end
            sbus_pkg::ST_MUL: state_next = sbus_pkg::ST_SUM;
            sbus_pkg::ST_SUM: state_next = sbus_pkg::ST_OUT;
            sbus_pkg::ST_OUT: begin
                if (m_acc) begin
                    if (m_tlast) begin
                        state_next = sbus_pkg::ST_RECV;
                    end else begin
                        ch_next    = ch_reg + 4'd1;
                        state_next = sbus_pkg::ST_MUL;
                    end
                end
            end
            default: state_next = sbus_pkg::ST_RECV;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= sbus_pkg::ST_RECV;
            pos_reg    <= sbus_pkg::PosHunt;
            ch_reg     <= 4'd0;
            factor_reg <= sbus_pkg::FactorReset;
            offset_reg <= sbus_pkg::OffsetReset;
        end else begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            ch_reg    <= ch_next;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == sbus_pkg::CfgScaleFactor) begin
                    factor_reg <= cfg_data;
                end else if (cfg_index == sbus_pkg::CfgScaleOffset) begin
                    offset_reg <= cfg_data;
                end
            end
        end
    end

    // Data bytes shift in from the top, so after 22 bytes byte 0 sits lowest;
    // each delivered channel shifts the next one down to bit 0.
    always_ff @(posedge aclk) begin
        if (s_acc && !hunting) begin
            if (pos_reg < sbus_pkg::PosFlag) begin
                data_reg <= {s_tdata, data_reg[sbus_pkg::DataBits-1:8]};
            end else begin
                flags_reg <= s_tdata;
            end
        end else if (m_acc) begin
            data_reg <= {{sbus_pkg::ChBits{1'b0}}, data_reg[sbus_pkg::DataBits-1:sbus_pkg::ChBits]};
        end
        if (state_reg == sbus_pkg::ST_SUM) begin
            value_reg <= scaled;
        end
    end

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(m_tvalid && s_tready))
        else $error("input taken during channel pass");

    a_flag_starts_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && !hunting && (pos_reg == sbus_pkg::PosFlag) |=> !s_tready && (ch_reg == 4'd0))
        else $error("flag byte did not start channel pass at channel 0");

    a_last_returns: assert property (@(posedge aclk) disable iff (!aresetn)
        m_acc && m_tlast |=> s_tready && (pos_reg == sbus_pkg::PosHunt))
        else $error("block did not return to hunting after last channel");

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= sbus_pkg::PosFlag)
        else $error("frame position out of range");

endmodule

// ===== sim/sbus_frame_checker.sv =====
// Scoreboard for the SBUS frame decoder: follows the byte stream and register
// writes, predicts each channel item and compares it with the master side.
// Depends on sbus_pkg.
module sbus_frame_checker (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_valid,
    input  logic                         cfg_ready,
    input  logic [sbus_pkg::CfgIdxW-1:0] cfg_index,
    input  logic [15:0]                  cfg_data,
    input  logic                         s_tvalid,
    input  logic                         s_tready,
    input  logic [7:0]                   s_tdata,
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic [31:0]                  m_tdata,
    input  logic                         m_tlast,
    output int                           mismatch_count,
    output int                           results_due
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [3:0]  chan;
        logic [15:0] value;
        logic [7:0]  flags;
        logic        last;
    } chan_result_t;

    logic [15:0]  factor_q;
    logic [15:0]  offset_q;
    logic [4:0]   frame_pos;
    logic [7:0]   frame_data [sbus_pkg::DataLen];
    chan_result_t channels_due [$];
    int           err_cnt = 0;

    task automatic decode_byte(input logic [7:0] rx);
        logic [sbus_pkg::DataBits-1:0] frame_bits;
        logic [sbus_pkg::ChBits-1:0]   raw;
        logic [sbus_pkg::ProdBits:0]   scaled;
        chan_result_t                  res;
        if (frame_pos == sbus_pkg::PosHunt || frame_pos > sbus_pkg::PosFlag) begin
            frame_pos = (rx == sbus_pkg::HdrByte) ? 5'd1 : sbus_pkg::PosHunt;
        end else if (frame_pos < sbus_pkg::PosFlag) begin
            // a header value here is plain data
            frame_data[frame_pos - 5'd1] = rx;
            frame_pos = frame_pos + 5'd1;
        end else begin
            for (int i = 0; i < sbus_pkg::DataLen; i++)
                frame_bits[8*i +: 8] = frame_data[i];
            for (int ch = 0; ch < sbus_pkg::NumCh; ch++) begin
                raw        = frame_bits[ch*sbus_pkg::ChBits +: sbus_pkg::ChBits];
                scaled     = (sbus_pkg::ProdBits+1)'(raw) * (sbus_pkg::ProdBits+1)'(factor_q)
                             + sbus_pkg::RoundBias;
                res.chan   = 4'(ch);
                res.value  = scaled[sbus_pkg::FracBits +: 16] + offset_q;   // wraps mod 2^16
                res.flags  = rx;
                res.last   = (4'(ch) == sbus_pkg::LastCh);
                channels_due.push_back(res);
            end
            frame_pos = sbus_pkg::PosHunt;
        end
    endtask

    function automatic void check_field(string what, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $display("%0t ns: %s expected %0h, got %0h", $time, what, want, got);
            err_cnt++;
        end
    endfunction

    always @(posedge aclk) begin
        chan_result_t want;
        if (!aresetn) begin
            factor_q  = sbus_pkg::FactorReset;
            offset_q  = sbus_pkg::OffsetReset;
            frame_pos = sbus_pkg::PosHunt;
            channels_due.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == sbus_pkg::CfgScaleFactor)
                    factor_q = cfg_data;
                else if (cfg_index == sbus_pkg::CfgScaleOffset)
                    offset_q = cfg_data;
            end
            if (s_tvalid && s_tready)
                decode_byte(s_tdata);
            if (m_tvalid && m_tready) begin
                if (channels_due.size() == 0) begin
                    $display("%0t ns: unexpected item, expected none, got %h last %b",
                             $time, m_tdata, m_tlast);
                    err_cnt++;
                end else begin
                    want = channels_due.pop_front();
                    check_field("channel_index", 16'(want.chan), 16'(m_tdata[3:0]));
                    check_field("channel_value", want.value, m_tdata[19:4]);
                    check_field("frame_flags", 16'(want.flags), 16'(m_tdata[27:20]));
                    check_field("last", 16'(want.last), 16'(m_tlast));
                end
            end
        end
        mismatch_count <= err_cnt;
        results_due    <= channels_due.size();
    end

endmodule

// ===== sim/tb.sv =====
// Testbench top for sbus_frame_decoder: clock, reset, byte and register
// stimulus, receiver back-pressure and the verdict.
// Depends on sbus_pkg, sbus_frame_decoder and sbus_frame_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          ByteTarget = 370;
    localparam int          CycleLimit = 200000;
    localparam int          HoldCycles = 400;
    localparam int          SettleCycles = 16;
    localparam logic [sbus_pkg::CfgIdxW-1:0] CfgSpareLo = 8'd2;
    localparam logic [sbus_pkg::CfgIdxW-1:0] CfgSpareHi = 8'hFF;

    typedef enum int { FILL_RANDOM, FILL_ZERO, FILL_ONES, FILL_HDR, FILL_MIXED } fill_t;
    typedef enum int { RX_OPEN, RX_COIN, RX_MOSTLY, RX_BEAT } rx_pattern_t;

    logic                         aclk;
    logic                         aresetn;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic [sbus_pkg::CfgIdxW-1:0] cfg_index;
    logic [15:0]                  cfg_data;
    logic                         s_tvalid;
    logic                         s_tready;
    logic [7:0]                   s_tdata;
    logic                         m_tvalid;
    logic                         m_tready;
    logic [31:0]                  m_tdata;
    logic                         m_tlast;

    int          mismatch_count;
    int          results_due;
    int          bytes_sent = 0;
    int          burst_left = 0;
    bit          gaps_on = 1'b1;
    bit          hold_req = 1'b0;
    logic [7:0]  frame_buf [sbus_pkg::DataLen];
    int          cycle_cnt = 0;

    sbus_frame_decoder dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    sbus_frame_checker chk (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .mismatch_count (mismatch_count),
        .results_due    (results_due)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        forever begin
            @(posedge aclk);
            cycle_cnt++;
            if (cycle_cnt > CycleLimit) begin
                $display("tb: done, errors");
                $finish;
            end
        end
    end

    // receiver: changing stall pattern, plus one long hold-off on request
    initial begin
        rx_pattern_t pattern;
        int          pattern_left;
        int          hold_left;
        int          beat;
        bit          hold_done;
        pattern      = RX_OPEN;
        pattern_left = 0;
        hold_left    = 0;
        beat         = 0;
        hold_done    = 1'b0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            beat++;
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HoldCycles;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                if (pattern_left == 0) begin
                    pattern      = rx_pattern_t'($urandom_range(RX_OPEN, RX_BEAT));
                    pattern_left = $urandom_range(20, 120);
                end
                pattern_left--;
                case (pattern)
                    RX_OPEN:   m_tready <= 1'b1;
                    RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
                    RX_MOSTLY: m_tready <= ($urandom_range(0, 4) != 0);
                    default:   m_tready <= ((beat % 5) < 3);
                endcase
            end
        end
    end

    task automatic put_byte(input logic [7:0] b);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if (gaps_on)
                gap = $urandom_range(1, 6);
        end
        burst_left--;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
    endtask

    task automatic fill_frame(input fill_t kind);
        for (int i = 0; i < sbus_pkg::DataLen; i++) begin
            case (kind)
                FILL_ZERO: frame_buf[i] = 8'h00;
                FILL_ONES: frame_buf[i] = 8'hFF;
                FILL_HDR:  frame_buf[i] = sbus_pkg::HdrByte;
                FILL_MIXED: begin
                    case ($urandom_range(0, 3))
                        0:       frame_buf[i] = 8'h00;
                        1:       frame_buf[i] = 8'hFF;
                        2:       frame_buf[i] = sbus_pkg::HdrByte;
                        default: frame_buf[i] = 8'($urandom_range(0, 255));
                    endcase
                end
                default:   frame_buf[i] = 8'($urandom_range(0, 255));
            endcase
        end
    endtask

    task automatic send_frame(input logic [7:0] flags);
        put_byte(sbus_pkg::HdrByte);
        for (int i = 0; i < sbus_pkg::DataLen; i++)
            put_byte(frame_buf[i]);
        put_byte(flags);
    endtask

    task automatic set_reg(input logic [sbus_pkg::CfgIdxW-1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // results_due is read only after a further clock edge, so it covers a flag item taken at this edge
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_due != 0) @(posedge aclk);
        repeat (SettleCycles) @(posedge aclk);
    endtask

    initial begin
        logic [15:0] factor_tab [6];
        logic [15:0] offset_tab [6];
        int          phase;
        factor_tab = '{16'd0, 16'hFFFF, 16'hFFFF, 16'd4096, 16'd1, 16'd2560};
        offset_tab = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000, 16'hFC00};
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= 8'h00;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: hunt noise, extreme data and flags, header as data and flag
        gaps_on = 1'b0;
        put_byte(8'h00);
        put_byte(8'hFF);
        put_byte(8'h0E);
        fill_frame(FILL_ZERO);
        send_frame(8'h00);
        fill_frame(FILL_ONES);
        send_frame(8'hFF);
        fill_frame(FILL_HDR);
        send_frame(sbus_pkg::HdrByte);
        wait_idle();

        // writes to unused indexes must leave the scaling alone
        set_reg(CfgSpareLo, 16'h1234);
        set_reg(CfgSpareHi, 16'hFFFF);
        fill_frame(FILL_MIXED);
        send_frame(8'h5A);
        wait_idle();

        phase = 0;
        while (bytes_sent < ByteTarget) begin
            if (phase < 6) begin
                set_reg(sbus_pkg::CfgScaleFactor, factor_tab[phase]);
                set_reg(sbus_pkg::CfgScaleOffset, offset_tab[phase]);
            end else begin
                set_reg(sbus_pkg::CfgScaleFactor, 16'($urandom_range(0, 65535)));
                set_reg(sbus_pkg::CfgScaleOffset, 16'($urandom_range(0, 65535)));
                if ($urandom_range(0, 3) == 0)
                    set_reg(8'($urandom_range(CfgSpareLo, CfgSpareHi)),
                            16'($urandom_range(0, 65535)));
            end
            if (phase == 3) begin
                // long receiver hold-off while bytes keep coming
                hold_req = 1'b1;
                gaps_on  = 1'b0;
                fill_frame(FILL_RANDOM);
                send_frame(8'($urandom_range(0, 255)));
                fill_frame(FILL_RANDOM);
                send_frame(8'($urandom_range(0, 255)));
            end else begin
                gaps_on = ($urandom_range(0, 3) != 0);
                repeat ($urandom_range(1, 3)) begin
                    case ($urandom_range(0, 9))
                        0: repeat ($urandom_range(1, 4)) put_byte(8'($urandom_range(0, 255)));
                        1: begin
                            // truncated frame; what follows is taken as its data
                            put_byte(sbus_pkg::HdrByte);
                            repeat ($urandom_range(0, 21)) put_byte(8'($urandom_range(0, 255)));
                        end
                        default: begin
                            fill_frame(fill_t'($urandom_range(FILL_RANDOM, FILL_MIXED)));
                            send_frame(8'($urandom_range(0, 255)));
                        end
                    endcase
                end
            end
            wait_idle();
            phase++;
        end

        wait_idle();
        if (mismatch_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
